// ----- design/hts_pkg.sv -----
// Shared constants, types and coefficient table for the harmonic tide sum block.
package hts_pkg;

    // serial multiplier: 48-bit multiplicand, 8-bit digits of a 48-bit multiplier
    localparam int MUL_W     = 48;
    localparam int DIGIT_W   = 8;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_STEPS = MUL_W / DIGIT_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // serial divider by a small constant: 32-bit numerator, 4 quotient bits a cycle
    localparam int DIV_W     = 32;
    localparam int DIV_K_W   = 8;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // 2*pi in Q.32
    localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_EPOCH  = 3'd0,
        CFG_TIME_OFFSET = 3'd1,
        CFG_MEAN_LEVEL  = 3'd2,
        CFG_SITE_OFFSET = 3'd3,
        CFG_LEVEL_SCALE = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANGLE,
        S_FOLD,
        S_SQUARE,
        S_SMUL,
        S_SDIV,
        S_SINX,
        S_AMP,
        S_OMH,
        S_OML,
        S_ORDER,
        S_ACCUM,
        S_LEVEL,
        S_OUT
    } t_state;

    // Horner divisors: cosine series, then sine series
    function automatic logic [DIV_K_W-1:0] series_k(input logic is_sin,
                                                     input logic [2:0] idx);
        logic [DIV_K_W-1:0] k;
        k = 8'd2;
        unique case ({is_sin, idx})
            4'b0000: k = 8'd132;
            4'b0001: k = 8'd90;
            4'b0010: k = 8'd56;
            4'b0011: k = 8'd30;
            4'b0100: k = 8'd12;
            4'b0101: k = 8'd2;
            4'b1000: k = 8'd156;
            4'b1001: k = 8'd110;
            4'b1010: k = 8'd72;
            4'b1011: k = 8'd42;
            4'b1100: k = 8'd20;
            4'b1101: k = 8'd6;
            default: k = 8'd2;
        endcase
        return k;
    endfunction

endpackage

// ----- design/hts_mul.sv -----
// Digit-serial unsigned multiplier, one 8-bit digit of the multiplier per cycle.
module hts_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hts_pkg::MUL_W-1:0]    i_a,
    input  logic [hts_pkg::MUL_W-1:0]    i_b,
    output logic [hts_pkg::PROD_W-1:0]   o_p,
    output logic                         o_done
);
    import hts_pkg::*;

    logic [MUL_W-1:0]     r_a;
    logic [MUL_W-1:0]     r_b;
    logic [PROD_W-1:0]    r_p;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [MUL_W+DIGIT_W-1:0] w_pp;
    logic [MUL_W+DIGIT_W:0]   w_sum;

    assign w_pp  = (MUL_W+DIGIT_W)'(r_a) * (MUL_W+DIGIT_W)'(r_b[DIGIT_W-1:0]);
    assign w_sum = (MUL_W+DIGIT_W+1)'(r_p[PROD_W-1:MUL_W]) + (MUL_W+DIGIT_W+1)'(w_pp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_b <= r_b >> DIGIT_W;
            r_p <= {w_sum[MUL_W+DIGIT_W-1:0], r_p[MUL_W-1:DIGIT_W]};
        end
    end

    assign o_p    = r_p;
    assign o_done = r_done;

endmodule

// ----- design/hts_div.sv -----
// Serial restoring divider by a small constant, four quotient bits per cycle.
module hts_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hts_pkg::DIV_W-1:0]     i_num,
    input  logic [hts_pkg::DIV_K_W-1:0]   i_k,
    output logic [hts_pkg::DIV_W-1:0]     o_quo,
    output logic                          o_done
);
    import hts_pkg::*;

    logic [DIV_W-1:0]     r_num;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_K_W-1:0]   r_rem;
    logic [DIV_K_W-1:0]   r_k;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_K_W-1:0]   w_rem;
    logic [DIV_BITS-1:0]  w_qbits;

    always_comb begin
        logic [DIV_K_W:0] t;
        w_rem   = r_rem;
        w_qbits = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {w_rem, r_num[DIV_W-1-i]};
            if (t >= {1'b0, r_k}) begin
                t = t - {1'b0, r_k};
                w_qbits[DIV_BITS-1-i] = 1'b1;
            end
            w_rem = t[DIV_K_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_k   <= i_k;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << DIV_BITS;
            r_rem <= w_rem;
            r_quo <= {r_quo[DIV_W-DIV_BITS-1:0], w_qbits};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ----- design/harmonic_tide_sum_top.sv -----
// Top level of the harmonic tide sum: sequencer, run state and output register.
//
// Usage:
//  Input channel (i_valid / o_stall): one item per constituent, carrying the
//  sample time, derivative order, speed, amplitude, phase and a last flag.
//  Items of one run are summed; the item with i_last_term set closes the run
//  and yields one result on the output channel (o_valid / i_stall).
//  Config channel (i_cfg_valid / o_cfg_ready): always ready; index selects
//  base epoch, time offset, mean level, site offset or level scale. Write only
//  while the block is idle.
// Flow:
//  An item keeps o_stall high from acceptance until the sequencer is idle again,
//  so a new item is taken only once the last one is through; a last item also
//  runs level scaling and loads the output register before its result is valid.
//  The work is done by the shared digit-serial multiplier (19 to 21 products per
//  item for order 0 to 2) and the serial constant divider (12 divisions per item).
//  Items are handled one at a time; o_stall is high while an item is at work.
// Reset: clears the run and the output valid and loads the register reset
//  values (level scale 1.0). If the receiver stalls, the result waits in the
//  output register; a following run proceeds and blocks only at its own end.
module harmonic_tide_sum_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [31:0]                        i_sample_time,
    input  logic [1:0]                         i_deriv_order,
    input  logic [39:0]                        i_speed_turns,
    input  logic [23:0]                        i_amplitude,
    input  logic [15:0]                        i_phase_turns,
    input  logic                               i_last_term,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [47:0]                 o_tide_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import hts_pkg::*;

    localparam logic signed [49:0] MAX48 = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic [32:0]        ONE_Q32 = 33'h1_0000_0000;

    // configuration
    logic [31:0]        r_base;
    logic [17:0]        r_toff;
    logic [23:0]        r_mean;
    logic [23:0]        r_soff;
    logic [15:0]        r_scale;

    // latched item
    logic [31:0]        r_stime;
    logic [1:0]         r_order;
    logic [39:0]        r_speed;
    logic [23:0]        r_amp;
    logic [15:0]        r_phase;
    logic               r_last;

    // working values
    t_state             r_state, n_state;
    logic               r_wait;
    logic [1:0]         r_q;
    logic               r_swap;
    logic [29:0]        r_r;
    logic [31:0]        r_x;
    logic [31:0]        r_x2;
    logic [31:0]        r_v;
    logic [32:0]        r_t;
    logic [32:0]        r_c;
    logic [2:0]         r_cnt;
    logic               r_sin;
    logic [32:0]        r_cmag;
    logic               r_neg;
    logic [39:0]        r_mag;
    logic [54:0]        r_omh;
    logic [43:0]        r_omega;
    logic [1:0]         r_ord_i;
    logic signed [47:0] r_sum;
    logic               r_run;
    logic [47:0]        r_res;
    logic               r_out_valid;
    logic [47:0]        r_out;

    // unit hookup
    logic               w_mul_start, w_mul_done;
    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [PROD_W-1:0]  w_mul_p;
    logic               w_div_start, w_div_done;
    logic [DIV_W-1:0]   w_div_quo;
    logic               w_out_free;

    hts_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_p     (w_mul_p),
        .o_done  (w_mul_done)
    );

    hts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_v),
        .i_k     (series_k(r_sin, r_cnt)),
        .o_quo   (w_div_quo),
        .o_done  (w_div_done)
    );

    // elapsed seconds, exact in 34 bits signed
    logic [33:0] w_elap;
    assign w_elap = {2'b00, r_stime} - {2'b00, r_base} + {{16{r_toff[17]}}, r_toff};

    // angle in Q0.48 turns, then fold to an eighth turn
    logic [47:0] w_angle;
    logic [29:0] w_rraw;
    assign w_angle = w_mul_p[47:0] + {r_phase, 32'h0} + {r_order, 46'h0};
    assign w_rraw  = w_angle[45:16];

    // Horner step result
    logic [32:0] w_tnext;
    assign w_tnext = ONE_Q32 - {1'b0, w_div_quo};

    // signed cosine from quadrant
    logic [32:0] w_s, w_ce, w_se;
    assign w_s  = {1'b0, w_mul_p[63:32]};
    assign w_ce = r_swap ? w_s : r_c;
    assign w_se = r_swap ? r_c : w_s;

    // omega = (sh*2pi + (sl*2pi >> 20)) >> 12
    logic [55:0] w_omsum;
    assign w_omsum = {1'b0, r_omh} + 56'(w_mul_p[54:20]);

    // accumulate with run start value and saturation
    logic signed [49:0] w_init, w_base, w_term, w_acc;
    logic signed [24:0] w_lvl;
    logic [47:0]        w_acc_sat;
    assign w_lvl  = {r_mean[23], r_mean} + {r_soff[23], r_soff};
    assign w_init = (r_order == 2'd0) ? {{9{w_lvl[24]}}, w_lvl, 16'h0} : '0;
    assign w_base = r_run ? {{2{r_sum[47]}}, r_sum} : w_init;
    assign w_term = r_neg ? -$signed({10'h0, r_mag}) : $signed({10'h0, r_mag});
    assign w_acc  = w_base + w_term;
    always_comb begin
        if (w_acc[49:47] == 3'b000 || w_acc[49:47] == 3'b111) begin
            w_acc_sat = w_acc[47:0];
        end else if (w_acc[49]) begin
            w_acc_sat = 48'h8000_0000_0000;
        end else begin
            w_acc_sat = MAX48[47:0];
        end
    end

    // level scale of the finished sum
    logic [47:0] w_abs_sum;
    logic [49:0] w_lmag;
    logic [47:0] w_lres;
    assign w_abs_sum = r_sum[47] ? 48'(-r_sum) : r_sum;
    assign w_lmag    = w_mul_p[63:14];
    always_comb begin
        if (!r_sum[47]) begin
            w_lres = (w_lmag[49:47] != 3'b000) ? MAX48[47:0] : w_lmag[47:0];
        end else begin
            w_lres = (w_lmag[49:47] != 3'b000) ? 48'h8000_0000_0000
                                                : 48'(-w_lmag[47:0]);
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_ANGLE;
            S_ANGLE:  if (w_mul_done) n_state = S_FOLD;
            S_FOLD:   if (w_mul_done) n_state = S_SQUARE;
            S_SQUARE: if (w_mul_done) n_state = S_SMUL;
            S_SMUL:   if (w_mul_done) n_state = S_SDIV;
            S_SDIV: begin
                if (w_div_done) begin
                    n_state = (r_cnt == 3'd5 && r_sin) ? S_SINX : S_SMUL;
                end
            end
            S_SINX:   if (w_mul_done) n_state = S_AMP;
            S_AMP:    if (w_mul_done) n_state = S_OMH;
            S_OMH:    if (w_mul_done) n_state = S_OML;
            S_OML: begin
                if (w_mul_done) n_state = (r_order == 2'd0) ? S_ACCUM : S_ORDER;
            end
            S_ORDER: begin
                if (w_mul_done && (r_ord_i + 2'd1 == r_order)) n_state = S_ACCUM;
            end
            S_ACCUM:  n_state = r_last ? S_LEVEL : S_IDLE;
            S_LEVEL:  if (w_mul_done) n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // unit launches and operands
    always_comb begin
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            S_ANGLE: begin
                w_mul_start = !r_wait;
                w_mul_a     = {{14{w_elap[33]}}, w_elap};
                w_mul_b     = {8'h0, r_speed};
            end
            S_FOLD: begin
                w_mul_start = !r_wait;
                w_mul_a     = {13'h0, TWO_PI_Q32};
                w_mul_b     = {18'h0, r_r};
            end
            S_SQUARE: begin
                w_mul_start = !r_wait;
                w_mul_a     = {16'h0, r_x};
                w_mul_b     = {16'h0, r_x};
            end
            S_SMUL: begin
                w_mul_start = !r_wait;
                w_mul_a     = {16'h0, r_x2};
                w_mul_b     = {15'h0, r_t};
            end
            S_SDIV: w_div_start = !r_wait;
            S_SINX: begin
                w_mul_start = !r_wait;
                w_mul_a     = {16'h0, r_x};
                w_mul_b     = {15'h0, r_t};
            end
            S_AMP: begin
                w_mul_start = !r_wait;
                w_mul_a     = {15'h0, r_cmag};
                w_mul_b     = {24'h0, r_amp};
            end
            S_OMH: begin
                w_mul_start = !r_wait;
                w_mul_a     = {13'h0, TWO_PI_Q32};
                w_mul_b     = {28'h0, r_speed[39:20]};
            end
            S_OML: begin
                w_mul_start = !r_wait;
                w_mul_a     = {13'h0, TWO_PI_Q32};
                w_mul_b     = {28'h0, r_speed[19:0]};
            end
            S_ORDER: begin
                w_mul_start = !r_wait;
                w_mul_a     = {8'h0, r_mag};
                w_mul_b     = {4'h0, r_omega};
            end
            S_LEVEL: begin
                w_mul_start = !r_wait;
                w_mul_a     = w_abs_sum;
                w_mul_b     = {32'h0, r_scale};
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_base      <= '0;
            r_toff      <= '0;
            r_mean      <= '0;
            r_soff      <= '0;
            r_scale     <= 16'd16384;
        end else begin
            r_state <= n_state;
            if (w_mul_start || w_div_start) begin
                r_wait <= 1'b1;
            end else if (w_mul_done || w_div_done) begin
                r_wait <= 1'b0;
            end
            if (r_state == S_ACCUM) begin
                r_sum <= w_acc_sat;
                r_run <= !r_last;
            end
            r_out_valid <= (r_state == S_OUT && w_out_free) || (r_out_valid && i_stall);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BASE_EPOCH:  r_base  <= i_cfg_data;
                    CFG_TIME_OFFSET: r_toff  <= i_cfg_data[17:0];
                    CFG_MEAN_LEVEL:  r_mean  <= i_cfg_data[23:0];
                    CFG_SITE_OFFSET: r_soff  <= i_cfg_data[23:0];
                    CFG_LEVEL_SCALE: r_scale <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_stime <= i_sample_time;
                    r_order <= (i_deriv_order == 2'd3) ? 2'd2 : i_deriv_order;
                    r_speed <= i_speed_turns;
                    r_amp   <= i_amplitude;
                    r_phase <= i_phase_turns;
                    r_last  <= i_last_term;
                end
            end
            S_ANGLE: begin
                if (w_mul_done) begin
                    r_q <= w_angle[47:46];
                    if (w_rraw > 30'h2000_0000) begin
                        r_r    <= 30'(31'h4000_0000 - {1'b0, w_rraw});
                        r_swap <= 1'b1;
                    end else begin
                        r_r    <= w_rraw;
                        r_swap <= 1'b0;
                    end
                end
            end
            S_FOLD: if (w_mul_done) r_x <= w_mul_p[63:32];
            S_SQUARE: begin
                if (w_mul_done) begin
                    r_x2  <= w_mul_p[63:32];
                    r_t   <= ONE_Q32;
                    r_cnt <= 3'd0;
                    r_sin <= 1'b0;
                end
            end
            S_SMUL: if (w_mul_done) r_v <= w_mul_p[63:32];
            S_SDIV: begin
                if (w_div_done) begin
                    if (r_cnt == 3'd5) begin
                        if (!r_sin) begin
                            r_c   <= w_tnext;
                            r_t   <= ONE_Q32;
                            r_sin <= 1'b1;
                            r_cnt <= 3'd0;
                        end else begin
                            r_t <= w_tnext;
                        end
                    end else begin
                        r_t   <= w_tnext;
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
            end
            S_SINX: begin
                if (w_mul_done) begin
                    r_cmag <= r_q[0] ? w_se : w_ce;
                    r_neg  <= r_q[1] ^ r_q[0];
                end
            end
            S_AMP: if (w_mul_done) r_mag <= w_mul_p[55:16];
            S_OMH: if (w_mul_done) r_omh <= w_mul_p[54:0];
            S_OML: begin
                if (w_mul_done) begin
                    r_omega <= w_omsum[55:12];
                    r_ord_i <= 2'd0;
                end
            end
            S_ORDER: begin
                if (w_mul_done) begin
                    r_mag   <= w_mul_p[87:48];
                    r_ord_i <= r_ord_i + 2'd1;
                end
            end
            S_LEVEL: if (w_mul_done) r_res <= w_lres;
            S_OUT:   if (w_out_free) r_out <= r_res;
            default: ;
        endcase
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_tide_value = r_out;
    assign o_cfg_ready  = 1'b1;

    // the two serial units never finish together
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("mul and div done together");

    // a result appears only from the output step
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output loaded outside output step");

    // no unit left running when a new item may enter
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_wait)
        else $error("unit busy in idle");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for harmonic_tide_sum_top: directed table, random runs, bit-exact predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hts_pkg::*;

    localparam int          STALL_LIMIT = 5000;  // idle cycles allowed before declaring a hang
    localparam int          DRAIN_WAIT  = 400;   // > one item plus level scaling
    localparam logic [63:0] MASK48      = 64'hFFFF_FFFF_FFFF;
    localparam longint      MAX48       = 64'sd140737488355327;
    localparam longint      MIN48       = -64'sd140737488355328;

    // one directed item; exp_known marks a result typed in by hand
    typedef struct {
        logic [31:0] stime;
        logic [1:0]  order;
        logic [39:0] speed;
        logic [23:0] amp;
        logic [15:0] phase;
        logic        last;
        logic        exp_known;
        logic [47:0] exp_value;
    } t_tide_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [31:0]           i_sample_time = '0;
    logic [1:0]            i_deriv_order = '0;
    logic [39:0]           i_speed_turns = '0;
    logic [23:0]           i_amplitude = '0;
    logic [15:0]           i_phase_turns = '0;
    logic                  i_last_term = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [47:0]    o_tide_value;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    harmonic_tide_sum_top u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of registers and run state
    logic [31:0]        cfg_base_epoch  = '0;
    logic signed [63:0] cfg_time_offset = '0;
    logic signed [63:0] cfg_mean_level  = '0;
    logic signed [63:0] cfg_site_offset = '0;
    logic [15:0]        cfg_level_scale = 16'd16384;
    logic signed [63:0] tide_acc  = '0;
    logic               run_open  = 1'b0;
    logic [47:0]        tide_expect_q[$];

    int  err_cnt = 0;
    int  items_in = 0;
    int  results_out = 0;
    int  cfg_writes = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  quiet_cycles = 0;
    t_tide_row dir_rows[$];

    // sign(a)*floor(|a|*b/2^sh), magnitude capped at 2^62
    function automatic logic signed [63:0] scale_trunc(logic signed [63:0] a,
                                                       logic [63:0] b, int sh);
        logic [63:0]        mag;
        logic [127:0]       prod;
        logic signed [63:0] r;
        mag  = (a < 0) ? -a : a;
        prod = ({64'b0, mag} * {64'b0, b}) >> sh;
        if (prod > (128'd1 << 62))
            prod = 128'd1 << 62;
        r = prod[63:0];
        return (a < 0) ? -r : r;
    endfunction

    function automatic logic signed [63:0] clip48(logic signed [63:0] v);
        if (v > MAX48) return MAX48;
        if (v < MIN48) return MIN48;
        return v;
    endfunction

    // Horner series in Q0.32, cosine or sine divisors
    function automatic logic [63:0] horner(logic [63:0] x2, logic is_sin);
        logic [63:0] t;
        logic [63:0] kc[6];
        logic [63:0] ks[6];
        kc = '{132, 90, 56, 30, 12, 2};
        ks = '{156, 110, 72, 42, 20, 6};
        t  = 64'd1 << 32;
        for (int i = 0; i < 6; i++)
            t = (64'd1 << 32) - ((x2 * t) >> 32) / (is_sin ? ks[i] : kc[i]);
        return t;
    endfunction

    // signed cosine of a Q0.32 turn angle, 1.0 = 2^32
    function automatic logic signed [63:0] cos_turns_q32(logic [31:0] a32);
        logic [1:0]  quad;
        logic [63:0] r, x, x2, c, s, ce, se;
        logic        swap;
        quad = a32[31:30];
        r    = {34'b0, a32[29:0]};
        swap = 1'b0;
        if (r > (64'd1 << 29)) begin
            r    = (64'd1 << 30) - r;
            swap = 1'b1;
        end
        x  = (r * 64'(TWO_PI_Q32)) >> 32;
        x2 = (x * x) >> 32;
        c  = horner(x2, 1'b0);
        s  = (x * horner(x2, 1'b1)) >> 32;
        ce = swap ? s : c;
        se = swap ? c : s;
        case (quad)
            2'd0: return $signed(ce);
            2'd1: return -$signed(se);
            2'd2: return -$signed(ce);
            default: return $signed(se);
        endcase
    endfunction

    // fold one accepted constituent into the running sum; queue a result on a last item
    task automatic tide_predict(input t_tide_row it);
        int                 ord;
        logic [63:0]        elapsed, angle, omega, spd;
        logic signed [63:0] term;
        ord = (it.order == 2'd3) ? 2 : int'(it.order);
        spd = {24'b0, it.speed};
        if (!run_open)
            tide_acc = (ord == 0) ? (cfg_mean_level + cfg_site_offset) * 64'sd65536 : '0;
        elapsed = $signed({32'b0, it.stime}) - $signed({32'b0, cfg_base_epoch})
                  + cfg_time_offset;
        angle = (spd * elapsed + ({48'b0, it.phase} << 32) + (64'(ord) << 46)) & MASK48;
        term  = scale_trunc(cos_turns_q32(angle[47:16]), {40'b0, it.amp}, 16);
        omega = ((spd >> 20) * 64'(TWO_PI_Q32)
                 + (((spd & 64'hFFFFF) * 64'(TWO_PI_Q32)) >> 20)) >> 12;
        for (int i = 0; i < ord; i++)
            term = scale_trunc(term, omega, 48);
        tide_acc = clip48(tide_acc + term);
        run_open = !it.last;
        if (it.last)
            tide_expect_q.push_back(it.exp_known ? it.exp_value :
                clip48(scale_trunc(tide_acc, {48'b0, cfg_level_scale}, 14)));
    endtask

    // drive one item; returns at the edge where it is taken
    task automatic send_item(input t_tide_row it);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid       <= 1'b1;
        i_sample_time <= it.stime;
        i_deriv_order <= it.order;
        i_speed_turns <= it.speed;
        i_amplitude   <= it.amp;
        i_phase_turns <= it.phase;
        i_last_term   <= it.last;
        do @(posedge i_clk); while (o_stall);
        items_in++;
        tide_predict(it);
    endtask

    // valid stays up between back-to-back writes; the caller drops it after the last
    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
        case (idx)
            CFG_BASE_EPOCH:  cfg_base_epoch  = data;
            CFG_TIME_OFFSET: cfg_time_offset = {{46{data[17]}}, data[17:0]};
            CFG_MEAN_LEVEL:  cfg_mean_level  = {{40{data[23]}}, data[23:0]};
            CFG_SITE_OFFSET: cfg_site_offset = {{40{data[23]}}, data[23:0]};
            CFG_LEVEL_SCALE: cfg_level_scale = data[15:0];
            default: ;
        endcase
    endtask

    // registers change only once every result is out and the last item has settled
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tide_expect_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [31:0] t, input logic [1:0] o, input logic [39:0] sp,
                           input logic [23:0] a, input logic [15:0] ph, input logic l,
                           input logic k, input logic [47:0] e);
        t_tide_row r;
        r = '{t, o, sp, a, ph, l, k, e};
        dir_rows.push_back(r);
    endtask

    // random speeds: half full range, half shifted down toward tidal rates
    function automatic logic [39:0] rand_speed();
        logic [39:0] s;
        s = 40'({$urandom, $urandom});
        if ($urandom_range(1)) s = s >> $urandom_range(39);
        return s;
    endfunction

    // receiver back-pressure
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < rx_stall_pct);

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_out++;
            if (tide_expect_q.size() == 0) begin
                $error("tide_value: unexpected result %0d", o_tide_value);
                err_cnt++;
            end else begin
                logic [47:0] want;
                want = tide_expect_q.pop_front();
                if (o_tide_value !== want) begin
                    $error("tide_value: expected %0d actual %0d", $signed(want), o_tide_value);
                    err_cnt++;
                end
            end
        end
    end

    // hang watchdog: any accepted item on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[harmonic_tide_sum_top] ERROR");
            $finish;
        end
    end

    initial begin
        t_tide_row it;
        int run_len;
        int phase_items[4];
        logic [31:0] run_time;
        logic [1:0]  run_order;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset register values (base 0, offset 0, scale 1.0)
        add_row(0, 0, 0, 0, 0, 1, 1, 48'd0);                        // zero amplitude
        add_row(0, 0, 0, 24'd65536, 0, 1, 1, 48'h1_0000_0000);       // cos 0 = 1.0
        add_row(0, 0, 0, 24'd65536, 16'h8000, 1, 1, -48'sh1_0000_0000); // half turn
        add_row(0, 0, 0, 24'd65536, 16'h4000, 1, 1, 48'd0);          // quarter turn
        add_row(0, 0, 0, 24'hFFFFFF, 0, 1, 1, 48'hFF_FFFF_0000);     // amplitude max
        add_row(0, 1, 0, 24'hFFFFFF, 0, 1, 1, 48'd0);                // zero speed, 1st deriv
        add_row(0, 2, 0, 24'hFFFFFF, 16'h4000, 1, 1, 48'd0);         // zero speed, 2nd deriv
        add_row(32'hFFFFFFFF, 3, 40'hFF_FFFF_FFFF, 24'hFFFFFF, 16'hFFFF, 1, 0, 0); // order 3
        add_row(0, 0, 0, 24'd1000, 16'h2000, 1, 0, 0);               // eighth-turn boundary
        add_row(0, 0, 0, 24'd1000, 16'h2001, 1, 0, 0);               // just past it
        add_row(32'hFFFFFFFF, 0, 40'd1, 24'd77777, 16'h1234, 1, 0, 0);
        add_row(32'd1, 1, 40'hFF_FFFF_FFFF, 24'd1, 0, 1, 0, 0);
        // mixed orders and times in one run
        add_row(32'd3600, 0, 40'd5_000_000, 24'd900000, 16'h0100, 0, 0, 0);
        add_row(32'd7200, 1, 40'd9_000_000, 24'd400000, 16'hA000, 0, 0, 0);
        add_row(32'd3600, 2, 40'd7_000_000, 24'd300000, 16'h7FFF, 0, 0, 0);
        add_row(32'd3600, 3, 40'd3_000_000, 24'd200000, 16'h3000, 1, 0, 0);
        // long first-derivative run
        for (int i = 0; i < 5; i++)
            add_row(32'd86400, 1, 40'd22_000_000 << i, 24'd500000, 16'(i * 9000),
                    (i == 4), 0, 0);
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // random phases: register setting and idling pattern change per phase
        phase_items = '{100, 600, 600, 650};
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            case (p)
                0: begin   // lower extremes, scale 0
                    cfg_write(CFG_BASE_EPOCH, 32'd0);
                    cfg_write(CFG_TIME_OFFSET, -32'sd86400);
                    cfg_write(CFG_MEAN_LEVEL, -32'sd8388608);
                    cfg_write(CFG_SITE_OFFSET, -32'sd8388608);
                    cfg_write(CFG_LEVEL_SCALE, 32'd0);
                end
                1: begin   // upper extremes; elapsed goes strongly negative
                    cfg_write(CFG_BASE_EPOCH, 32'hFFFFFFFF);
                    cfg_write(CFG_TIME_OFFSET, 32'd86400);
                    cfg_write(CFG_MEAN_LEVEL, 32'd8388607);
                    cfg_write(CFG_SITE_OFFSET, 32'd8388607);
                    cfg_write(CFG_LEVEL_SCALE, 32'd65535);
                end
                default: begin
                    cfg_write(CFG_BASE_EPOCH, $urandom);
                    cfg_write(CFG_TIME_OFFSET, $urandom_range(172800) - 86400);
                    cfg_write(CFG_MEAN_LEVEL, $urandom_range(24'hFFFFFF) - 8388608);
                    cfg_write(CFG_SITE_OFFSET, $urandom_range(24'hFFFFFF) - 8388608);
                    cfg_write(CFG_LEVEL_SCALE, $urandom_range(65535));
                end
            endcase
            i_cfg_valid <= 1'b0;
            tx_idle_pct  = (p < 2) ? 10 : (p == 2) ? 46 : 0;
            rx_stall_pct = (p < 2) ? 46 : (p == 2) ? 10 : 0;

            for (int n = 0; n < phase_items[p]; n += run_len) begin
                run_len   = $urandom_range(1, 8);
                run_time  = $urandom_range(3) ? $urandom : $urandom_range(2000);
                run_order = 2'($urandom_range(3));
                for (int k = 0; k < run_len; k++) begin
                    it.stime = ($urandom_range(9) == 0) ? $urandom : run_time;
                    it.order = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : run_order;
                    it.speed = rand_speed();
                    it.amp   = 24'($urandom_range(24'hFFFFFF) >> $urandom_range(23));
                    it.phase = 16'($urandom);
                    // a few broken runs: early or missing last flags
                    it.last  = ($urandom_range(19) == 0) ? 1'($urandom) : (k == run_len - 1);
                    it.exp_known = 1'b0;
                    it.exp_value = '0;
                    send_item(it);
                end
            end
            // close any run left open so the phase ends idle
            if (run_open) begin
                it.last = 1'b1;
                send_item(it);
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (tide_expect_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tide_expect_q.size() != 0) begin
            $error("tide_value: %0d expected results never arrived", tide_expect_q.size());
            err_cnt++;
        end
        $display("Run covered %0d constituent items, %0d tide results, %0d register writes",
                 items_in, results_out, cfg_writes);
        $display("across reset, lower-extreme, upper-extreme and random register settings.");
        if (err_cnt == 0)
            $display("[harmonic_tide_sum_top] OK");
        else
            $display("[harmonic_tide_sum_top] ERROR");
        $finish;
    end
endmodule
